FILE: sv/egs_pkg.sv
package egs_pkg;

    // Input function codes
    localparam logic FUNC_UPDATE  = 1'b0;
    localparam logic FUNC_RESCHED = 1'b1;

    localparam int TOTAL_W   = 15;
    localparam int TOTAL_MAX = 32767;

    // One process entry as stored in the table memory
    typedef struct packed {
        logic       run;
        logic [6:0] prio;
        logic [6:0] pend;
        logic [7:0] cnt;
        logic [7:0] quant;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_CUR_RD,
        ST_CUR_WR,
        ST_CHK,
        ST_FILL,
        ST_PICK,
        ST_OUT
    } state_t;

endpackage

FILE: sv/egs_ram.sv
module egs_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/epoch_goodness_scheduler.sv
// Update word: reads the entry, then writes it back unless the pid is out of range; no result.
// Reschedule word: writes back the current entry, then checks the table, refills it when a new
// epoch starts and picks a winner; each pass over the process table reads one entry a cycle.
// One word is in flight at a time; the result register frees the core while a result waits.
// rst_n (async, active low) clears control state, current pid, epoch total and the per-entry
// valid bits, so every table entry reads as zero until first written; no clearing pass.
module epoch_goodness_scheduler
    import egs_pkg::*;
#(
    parameter int NUM_PROCS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [5:0]           pid,
    input  logic                 runnable,
    input  logic [6:0]           new_priority,
    input  logic [7:0]           remaining_ticks,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [5:0]           next_pid,
    output logic [7:0]           time_slice,
    output logic                 switched,
    output logic                 new_epoch,
    output logic [TOTAL_W-1:0]   epoch_total
);

    localparam int IDX_W  = $clog2(NUM_PROCS);
    localparam int SCAN_W = IDX_W + 1;

    // Control and sequencing
    state_t state_reg, state_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic dv_reg, dv_next;                   // table read data valid this cycle
    logic [IDX_W-1:0] didx_reg, didx_next;   // index of the data now on the RAM port
    logic rv_reg, rv_next;                   // entry behind that data was ever written
    logic [NUM_PROCS-1:0] valid_reg, valid_next;

    // Captured input word
    logic [IDX_W-1:0] pid_reg, pid_next;
    logic pid_ok_reg, pid_ok_next;
    logic run_reg, run_next;
    logic [6:0] newp_reg, newp_next;
    logic [7:0] left_reg, left_next;

    // Scheduler state and scratch
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [TOTAL_W-1:0] esum_reg, esum_next;
    logic fresh_reg, fresh_next;
    logic [8:0] best_reg, best_next;
    logic [IDX_W-1:0] chosen_reg, chosen_next;
    logic [7:0] slice_reg, slice_next;

    // Result register
    logic out_valid_reg, out_valid_next;
    logic [5:0] next_pid_reg, next_pid_next;
    logic [7:0] time_slice_reg, time_slice_next;
    logic switched_reg, switched_next;
    logic new_epoch_reg, new_epoch_next;
    logic [TOTAL_W-1:0] epoch_total_reg, epoch_total_next;

    // Table memory port
    logic ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    ent_t ram_wdata;
    logic [ENT_W-1:0] ram_q;
    ent_t ent;

    // Helpers on the entry now read
    logic issuing;
    logic last_data;
    logic [8:0] good;
    logic [7:0] quant_new;
    logic [15:0] sum_wide;
    logic signed [16:0] adj;
    logic out_free;

    egs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // Never-written entries read as the reset value
    assign ent = rv_reg ? ent_t'(ram_q) : '0;

    assign issuing   = (scan_reg < SCAN_W'(NUM_PROCS));
    assign last_data = !issuing && dv_reg;
    assign good      = (ent.cnt == 8'd0) ? 9'd0 : ({1'b0, ent.cnt} + {2'b0, ent.prio});
    assign quant_new = {1'b0, ent.cnt[7:1]} + {1'b0, ent.pend};
    assign sum_wide  = {1'b0, esum_reg} + {8'd0, quant_new};
    assign adj       = $signed({2'b00, esum_reg}) - $signed({9'd0, ent.quant})
                       + $signed({9'd0, left_reg});
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign next_pid    = next_pid_reg;
    assign time_slice  = time_slice_reg;
    assign switched    = switched_reg;
    assign new_epoch   = new_epoch_reg;
    assign epoch_total = epoch_total_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (func == FUNC_RESCHED) ? ST_CUR_RD : ST_UPD_RD;
                end
            end
            ST_UPD_RD: state_next = pid_ok_reg ? ST_UPD_WR : ST_IDLE;
            ST_UPD_WR: state_next = ST_IDLE;
            ST_CUR_RD: state_next = ST_CUR_WR;
            ST_CUR_WR: state_next = ST_CHK;
            ST_CHK:
            begin
                if (last_data)
                begin
                    // no runnable entry with a live counter: refill the table
                    if (fresh_reg && !(ent.run && ent.cnt != 8'd0))
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_FILL: state_next = last_data ? ST_PICK : ST_FILL;
            ST_PICK: state_next = last_data ? ST_OUT : ST_PICK;
            ST_OUT:  state_next = out_free ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        scan_next        = scan_reg;
        dv_next          = 1'b0;
        didx_next        = didx_reg;
        rv_next          = rv_reg;
        valid_next       = valid_reg;
        pid_next         = pid_reg;
        pid_ok_next      = pid_ok_reg;
        run_next         = run_reg;
        newp_next        = newp_reg;
        left_next        = left_reg;
        cur_next         = cur_reg;
        esum_next        = esum_reg;
        fresh_next       = fresh_reg;
        best_next        = best_reg;
        chosen_next      = chosen_reg;
        slice_next       = slice_reg;
        out_valid_next   = out_valid_reg && out_stall;
        next_pid_next    = next_pid_reg;
        time_slice_next  = time_slice_reg;
        switched_next    = switched_reg;
        new_epoch_next   = new_epoch_reg;
        epoch_total_next = epoch_total_reg;
        ram_we           = 1'b0;
        ram_waddr        = didx_reg;
        ram_wdata        = ent;
        ram_raddr        = scan_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pid_next    = IDX_W'(pid);
                    pid_ok_next = (32'(pid) < NUM_PROCS);
                    run_next    = runnable;
                    newp_next   = new_priority;
                    left_next   = remaining_ticks;
                end
            end
            ST_UPD_RD:
            begin
                ram_raddr = pid_reg;
                rv_next   = valid_reg[pid_reg];
            end
            ST_UPD_WR:
            begin
                ram_we               = 1'b1;
                ram_waddr            = pid_reg;
                ram_wdata            = ent;
                ram_wdata.run        = run_reg;
                ram_wdata.pend       = newp_reg;
                valid_next[pid_reg]  = 1'b1;
            end
            ST_CUR_RD:
            begin
                ram_raddr = cur_reg;
                rv_next   = valid_reg[cur_reg];
            end
            ST_CUR_WR:
            begin
                // store leftover ticks, trade old quantum for them in the total
                ram_we              = 1'b1;
                ram_waddr           = cur_reg;
                ram_wdata           = ent;
                ram_wdata.cnt       = left_reg;
                valid_next[cur_reg] = 1'b1;
                if (adj < 0)
                begin
                    esum_next = '0;
                end
                else if (adj > 17'sd32767)
                begin
                    esum_next = TOTAL_W'(TOTAL_MAX);
                end
                else
                begin
                    esum_next = adj[TOTAL_W-1:0];
                end
                scan_next  = SCAN_W'(1);
                fresh_next = 1'b1;
            end
            ST_CHK, ST_FILL, ST_PICK:
            begin
                if (issuing)
                begin
                    ram_raddr = scan_reg[IDX_W-1:0];
                    rv_next   = valid_reg[scan_reg[IDX_W-1:0]];
                    didx_next = scan_reg[IDX_W-1:0];
                    dv_next   = 1'b1;
                    scan_next = scan_reg + SCAN_W'(1);
                end
                if (state_reg == ST_CHK)
                begin
                    if (dv_reg && ent.run && ent.cnt != 8'd0)
                    begin
                        fresh_next = 1'b0;
                    end
                    if (last_data)
                    begin
                        if (fresh_reg && !(ent.run && ent.cnt != 8'd0))
                        begin
                            scan_next = SCAN_W'(1);
                            esum_next = '0;
                        end
                        else
                        begin
                            scan_next   = '0;
                            best_next   = '0;
                            chosen_next = '0;
                        end
                    end
                end
                else if (state_reg == ST_FILL)
                begin
                    // new epoch: apply pending priority, refill counter and quantum
                    if (dv_reg)
                    begin
                        ram_we              = 1'b1;
                        ram_waddr           = didx_reg;
                        ram_wdata           = ent;
                        ram_wdata.prio      = ent.pend;
                        ram_wdata.cnt       = quant_new;
                        ram_wdata.quant     = quant_new;
                        valid_next[didx_reg] = 1'b1;
                        esum_next = (sum_wide > 16'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                                : sum_wide[TOTAL_W-1:0];
                    end
                    if (last_data)
                    begin
                        scan_next   = '0;
                        best_next   = '0;
                        chosen_next = '0;
                    end
                end
                else
                begin
                    if (dv_reg)
                    begin
                        // idle entry supplies the slice when nobody wins
                        if (didx_reg == '0)
                        begin
                            slice_next = ent.cnt;
                        end
                        if (ent.run && good > best_reg)
                        begin
                            best_next   = good;
                            chosen_next = didx_reg;
                            slice_next  = ent.cnt;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    next_pid_next    = 6'(chosen_reg);
                    time_slice_next  = slice_reg;
                    switched_next    = (chosen_reg != cur_reg);
                    new_epoch_next   = fresh_reg;
                    epoch_total_next = esum_reg;
                    cur_next         = chosen_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            dv_reg        <= 1'b0;
            valid_reg     <= '0;
            cur_reg       <= '0;
            esum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            dv_reg        <= dv_next;
            valid_reg     <= valid_next;
            cur_reg       <= cur_next;
            esum_reg      <= esum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg        <= didx_next;
        rv_reg          <= rv_next;
        pid_reg         <= pid_next;
        pid_ok_reg      <= pid_ok_next;
        run_reg         <= run_next;
        newp_reg        <= newp_next;
        left_reg        <= left_next;
        fresh_reg       <= fresh_next;
        best_reg        <= best_next;
        chosen_reg      <= chosen_next;
        slice_reg       <= slice_next;
        next_pid_reg    <= next_pid_next;
        time_slice_reg  <= time_slice_next;
        switched_reg    <= switched_next;
        new_epoch_reg   <= new_epoch_next;
        epoch_total_reg <= epoch_total_next;
    end

endmodule

FILE: bench/epoch_goodness_scheduler_tb.sv
`timescale 1ns / 1ps

module epoch_goodness_scheduler_tb
    import egs_pkg::*;
();

    localparam int NUM_PROCS      = 64;
    // A reschedule that starts an epoch walks the table three times; allow that
    // plus long receiver stalls many times over before calling the run hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Quiet time after the last result: one full epoch reschedule and then some.
    localparam int SETTLE_CYCLES  = 3 * NUM_PROCS + 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       func;
        logic [5:0] pid;
        logic       runnable;
        logic [6:0] new_priority;
        logic [7:0] remaining_ticks;
    } word_t;

    typedef struct packed {
        logic [5:0]         next_pid;
        logic [7:0]         time_slice;
        logic               switched;
        logic               new_epoch;
        logic [TOTAL_W-1:0] epoch_total;
    } pick_t;

    // Clock, reset and every block input start from known values.
    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_stall;
    logic               func            = FUNC_UPDATE;
    logic [5:0]         pid             = '0;
    logic               runnable        = 1'b0;
    logic [6:0]         new_priority    = '0;
    logic [7:0]         remaining_ticks = '0;
    logic               out_valid;
    logic               out_stall       = 1'b0;
    logic [5:0]         next_pid;
    logic [7:0]         time_slice;
    logic               switched;
    logic               new_epoch;
    logic [TOTAL_W-1:0] epoch_total;

    // Shadow copy of the process table and scheduler registers.
    logic               proc_run   [NUM_PROCS];
    logic [6:0]         proc_prio  [NUM_PROCS];
    logic [6:0]         proc_pend  [NUM_PROCS];
    logic [7:0]         proc_cnt   [NUM_PROCS];
    logic [7:0]         proc_quant [NUM_PROCS];
    logic [5:0]         running_pid;
    int                 quanta_left;

    word_t              words_to_send[$];
    pick_t              picks_due[$];
    word_t              next_word;
    pick_t              due;
    int                 sender_idle_pct = 13;
    int                 sink_stall_pct  = 52;
    int                 mismatches      = 0;
    int                 quiet_cycles    = 0;

    epoch_goodness_scheduler #(
        .NUM_PROCS (NUM_PROCS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .pid             (pid),
        .runnable        (runnable),
        .new_priority    (new_priority),
        .remaining_ticks (remaining_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_pid        (next_pid),
        .time_slice      (time_slice),
        .switched        (switched),
        .new_epoch       (new_epoch),
        .epoch_total     (epoch_total)
    );

    always #5 clk = ~clk;

    // Goodness is zero for an exhausted counter, else counter plus priority.
    function automatic int goodness(input int idx);
        if (proc_cnt[idx] == 8'd0)
            return 0;
        return int'(proc_cnt[idx]) + int'(proc_prio[idx]);
    endfunction

    // Advance the shadow scheduler by one accepted word and queue the pick it
    // should produce. Update words only touch the table and produce nothing.
    task automatic schedule_word(input word_t w);
        int    cur;
        int    best;
        int    chosen;
        int    sum;
        bit    fresh;
        pick_t p;
        if (w.func == FUNC_UPDATE)
        begin
            if (w.pid < NUM_PROCS)
            begin
                proc_run[w.pid]  = w.runnable;
                proc_pend[w.pid] = w.new_priority;
            end
        end
        else
        begin
            // Charge the leftover ticks back to the running entry.
            cur = running_pid;
            proc_cnt[cur] = w.remaining_ticks;
            sum = quanta_left - int'(proc_quant[cur]) + int'(w.remaining_ticks);
            quanta_left = (sum < 0) ? 0 : (sum > TOTAL_MAX) ? TOTAL_MAX : sum;

            // The idle entry never holds an epoch open.
            fresh = 1'b1;
            for (int i = 1; i < NUM_PROCS; i++)
                if (proc_run[i] && goodness(i) > 0)
                    fresh = 1'b0;

            // New epoch: refill every entry but the idle one, runnable or not.
            if (fresh)
            begin
                sum = 0;
                for (int i = 1; i < NUM_PROCS; i++)
                begin
                    proc_prio[i]  = proc_pend[i];
                    proc_quant[i] = {1'b0, proc_cnt[i][7:1]} + {1'b0, proc_prio[i]};
                    proc_cnt[i]   = proc_quant[i];
                    sum += int'(proc_quant[i]);
                    if (sum > TOTAL_MAX)
                        sum = TOTAL_MAX;
                end
                quanta_left = sum;
            end

            // Strictly greater wins, so the lowest entry takes a tie; fall back to 0.
            best   = 0;
            chosen = 0;
            for (int i = 0; i < NUM_PROCS; i++)
                if (proc_run[i] && goodness(i) > best)
                begin
                    best   = goodness(i);
                    chosen = i;
                end

            p.next_pid    = chosen[5:0];
            p.time_slice  = proc_cnt[chosen];
            p.switched    = (chosen != cur);
            p.new_epoch   = fresh;
            p.epoch_total = quanta_left[TOTAL_W-1:0];
            running_pid   = chosen[5:0];
            picks_due.push_back(p);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $realtime, name, want, got);
        end
    endtask

    // Pick a pid: mostly a small cluster at each end of the table so the same
    // entries get reused, sometimes anywhere.
    function automatic logic [5:0] any_pid();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 6'($urandom_range(7));
        if (roll < 70)
            return 6'($urandom_range(63, 56));
        return 6'($urandom_range(63));
    endfunction

    function automatic logic [6:0] any_prio();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 7'd0;
        if (roll == 1)
            return 7'd127;
        return 7'($urandom_range(127));
    endfunction

    // Fields that a word does not use still carry random noise.
    task automatic push_update(input logic [5:0] p, input logic r, input logic [6:0] np);
        word_t w;
        w.func            = FUNC_UPDATE;
        w.pid             = p;
        w.runnable        = r;
        w.new_priority    = np;
        w.remaining_ticks = 8'($urandom_range(255));
        words_to_send.push_back(w);
    endtask

    task automatic push_resched(input logic [7:0] ticks);
        word_t w;
        w.func            = FUNC_RESCHED;
        w.pid             = 6'($urandom_range(63));
        w.runnable        = 1'($urandom_range(1));
        w.new_priority    = 7'($urandom_range(127));
        w.remaining_ticks = ticks;
        words_to_send.push_back(w);
    endtask

    // Random traffic built from short scenarios rather than independent words,
    // so epochs roll over often and the epoch total gets pushed to both bounds.
    task automatic fill_random(input int quota);
        int made;
        int len;
        made = 0;
        while (made < quota)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    // Wake or retune a few entries.
                    len = $urandom_range(6, 1);
                    repeat (len)
                        push_update(any_pid(), $urandom_range(99) < 65, any_prio());
                end
                2:
                begin
                    // Put a batch to sleep so the runnable set stays small.
                    len = $urandom_range(16, 4);
                    repeat (len)
                        push_update(any_pid(), 1'b0, any_prio());
                end
                3, 4:
                begin
                    // Burn slices to zero until the epoch runs out.
                    len = $urandom_range(30, 3);
                    repeat (len)
                        push_resched(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                               : 8'd0);
                end
                5:
                begin
                    // Winner keeps handing back a full counter: total climbs to the top.
                    len = $urandom_range(180, 40);
                    repeat (len)
                        push_resched(8'($urandom_range(255, 200)));
                end
                6:
                begin
                    // Winner hands back almost nothing: total sinks toward zero.
                    len = $urandom_range(60, 10);
                    repeat (len)
                        push_resched(8'($urandom_range(3)));
                end
                default:
                begin
                    len = $urandom_range(10, 1);
                    repeat (len)
                        if ($urandom_range(3) == 0)
                            push_update(6'($urandom_range(63)), 1'($urandom_range(1)),
                                        7'($urandom_range(127)));
                        else
                            push_resched(8'($urandom_range(255)));
                end
            endcase
            made += len;
        end
    endtask

    // Driver: hold a stalled word, otherwise take the next pending word or
    // idle at random. The shadow model advances on the word that was accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            func            <= FUNC_UPDATE;
            pid             <= '0;
            runnable        <= 1'b0;
            new_priority    <= '0;
            remaining_ticks <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                schedule_word({func, pid, runnable, new_priority, remaining_ticks});
            if (!in_valid || !in_stall)
            begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_word        = words_to_send.pop_front();
                    in_valid        <= 1'b1;
                    func            <= next_word.func;
                    pid             <= next_word.pid;
                    runnable        <= next_word.runnable;
                    new_priority    <= next_word.new_priority;
                    remaining_ticks <= next_word.remaining_ticks;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest pending pick,
    // then decide whether to stall the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (picks_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word with nothing expected, next_pid %0d",
                                 $realtime, next_pid);
                end
                else
                begin
                    due = picks_due.pop_front();
                    check_field("next_pid", 16'(due.next_pid), 16'(next_pid));
                    check_field("time_slice", 16'(due.time_slice), 16'(time_slice));
                    check_field("switched", 16'(due.switched), 16'(switched));
                    check_field("new_epoch", 16'(due.new_epoch), 16'(new_epoch));
                    check_field("epoch_total", 16'(due.epoch_total), 16'(epoch_total));
                end
            end
            out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Watchdog: any accepted word on either side counts as progress.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_PROCS; i++)
        begin
            proc_run[i]   = 1'b0;
            proc_prio[i]  = '0;
            proc_pend[i]  = '0;
            proc_cnt[i]   = '0;
            proc_quant[i] = '0;
        end
        running_pid = '0;
        quanta_left = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            // Sender-light/receiver-heavy, then the reverse, then full speed.
            case (phase)
                0:
                begin
                    sender_idle_pct = 13;
                    sink_stall_pct  = 52;
                end
                1:
                begin
                    sender_idle_pct = 52;
                    sink_stall_pct  = 13;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
            endcase

            if (phase == 0)
            begin
                // Empty table right after reset: epoch of zero quanta, idle entry wins.
                push_resched(8'd0);
                push_update(6'd63, 1'b1, 7'd127);
                push_update(6'd1, 1'b1, 7'd0);
                // Pending priority on the idle entry is never applied.
                push_update(6'd0, 1'b1, 7'd100);
                push_update(6'd42, 1'b0, 7'd77);
                push_update(6'd21, 1'b1, 7'd85);
                // Idle entry gets a full counter and outranks every refilled entry.
                push_resched(8'd255);
                push_resched(8'd0);
                push_resched(8'd255);
                push_resched(8'd0);
                push_resched(8'd0);
                // Two entries with equal goodness: the lower pid must win.
                push_update(6'd5, 1'b1, 7'd10);
                push_update(6'd9, 1'b1, 7'd10);
                push_update(6'd63, 1'b0, 7'd0);
                push_update(6'd21, 1'b0, 7'd0);
                push_resched(8'd0);
                push_resched(8'd0);
                push_resched(8'd170);
                // Running entry goes to sleep before its reschedule.
                push_update(6'd9, 1'b0, 7'd127);
                push_resched(8'd1);
                push_update(6'd0, 1'b0, 7'd0);
                push_resched(8'd128);
                push_resched(8'd85);
            end

            fill_random(phase == 2 ? 630 : 650);

            // Hold off between phases until every word is in and every pick is out.
            while (words_to_send.size() != 0 || in_valid || picks_due.size() != 0)
                @(negedge clk);
        end

        // Let any stray result show up before judging the run.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && picks_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
